@@ src/bcps_pkg.sv @@
// ----------------------------------------------------------------------------
// bcps_pkg
// Types and constants shared by the cubic Bezier point sampler.
// ----------------------------------------------------------------------------
`default_nettype none

package bcps_pkg;

  localparam int unsigned CTRL_POINTS = 4;
  localparam int unsigned MAX_SAMPLES = 512;
  localparam int unsigned COORD_W     = 32;
  localparam int unsigned IDX_W       = 9;
  localparam int unsigned CNT_W       = 10;
  localparam int unsigned M_W         = 9;   // m = count - 1, up to 511
  localparam int unsigned SQ_W        = 2 * M_W;
  localparam int unsigned CUBE_W      = 3 * M_W;
  localparam int unsigned PROD_W      = CUBE_W + 1 + COORD_W;
  localparam int unsigned SUM_W       = PROD_W + 2;
  localparam int unsigned REM_W       = SUM_W - 1;
  localparam int unsigned QUO_W       = 32;  // quotient bits, one per cell
  localparam int unsigned SH_W        = 5;

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SAMPLES);

  localparam logic [2:0] REG_CTRL0_X = 3'd0;
  localparam logic [2:0] REG_CTRL0_Y = 3'd1;
  localparam logic [2:0] REG_CTRL1_X = 3'd2;
  localparam logic [2:0] REG_CTRL1_Y = 3'd3;
  localparam logic [2:0] REG_CTRL2_X = 3'd4;
  localparam logic [2:0] REG_CTRL2_Y = 3'd5;
  localparam logic [2:0] REG_CTRL3_X = 3'd6;
  localparam logic [2:0] REG_CTRL3_Y = 3'd7;

  typedef struct packed {
    logic [IDX_W-1:0] sample_index;
    logic [CNT_W-1:0] point_count;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic                      last_sample;
    logic                      index_error;
  } out_item_t;

  // one slot of the divider chain
  typedef struct packed {
    logic              valid;
    logic [REM_W-1:0]  rem_x;
    logic [REM_W-1:0]  rem_y;
    logic [CUBE_W-1:0] den;
    logic [QUO_W-1:0]  quo_x;
    logic [QUO_W-1:0]  quo_y;
    logic              neg_x;
    logic              neg_y;
    logic              last;
    logic              err;
  } div_slot_t;

endpackage

`default_nettype wire

@@ src/bcps_front.sv @@
// ----------------------------------------------------------------------------
// bcps_front
// Weight pipeline: Bernstein weights, weighted sums, rounding offset.
// ----------------------------------------------------------------------------
`default_nettype none

module bcps_front (
  input  wire                                          clk_i,
  input  wire                                          rst_ni,
  input  wire                                          en_i,
  input  wire                                          valid_i,
  input  bcps_pkg::in_item_t                           item_i,
  input  wire  [bcps_pkg::CTRL_POINTS-1:0][bcps_pkg::COORD_W-1:0] ctrl_x_i,
  input  wire  [bcps_pkg::CTRL_POINTS-1:0][bcps_pkg::COORD_W-1:0] ctrl_y_i,
  output bcps_pkg::div_slot_t                          slot_o
);
  import bcps_pkg::*;

  // stage 0: count saturation, flags, clamped index
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] idx_ext;
  logic [M_W-1:0]   m_d, a_d;
  logic             v0_q, last0_q, err0_q;
  logic [M_W-1:0]   m0_q, a0_q, b0_q;

  always_comb begin
    cnt     = (item_i.point_count > CNT_MAX) ? CNT_MAX : item_i.point_count;
    idx_ext = CNT_W'(item_i.sample_index);
    if (cnt < CNT_W'(2)) begin
      m_d = M_W'(1);
      a_d = '0;
    end else begin
      m_d = M_W'(cnt - CNT_W'(1));
      a_d = (item_i.sample_index > m_d) ? m_d : item_i.sample_index;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en_i) begin
      v0_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m0_q    <= m_d;
      a0_q    <= a_d;
      b0_q    <= m_d - a_d;
      err0_q  <= idx_ext >= cnt;
      last0_q <= (cnt != '0) && (idx_ext == cnt - CNT_W'(1));
    end
  end

  // stage 1: squares and cross term
  logic              v1_q, last1_q, err1_q;
  logic [M_W-1:0]    m1_q, a1_q, b1_q;
  logic [SQ_W-1:0]   aa1_q, bb1_q, ab1_q, mm1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m1_q    <= m0_q;
      a1_q    <= a0_q;
      b1_q    <= b0_q;
      aa1_q   <= SQ_W'(a0_q * a0_q);
      bb1_q   <= SQ_W'(b0_q * b0_q);
      ab1_q   <= SQ_W'(a0_q * b0_q);
      mm1_q   <= SQ_W'(m0_q * m0_q);
      last1_q <= last0_q;
      err1_q  <= err0_q;
    end
  end

  // stage 2: cubic weights and denominator m^3
  logic [CUBE_W-1:0] abb, aab;
  logic              v2_q, last2_q, err2_q;
  logic [CUBE_W-1:0] w2_q [CTRL_POINTS];
  logic [CUBE_W-1:0] den2_q;

  assign abb = CUBE_W'(ab1_q * b1_q);
  assign aab = CUBE_W'(ab1_q * a1_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en_i) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      w2_q[0] <= CUBE_W'(bb1_q * b1_q);
      w2_q[1] <= (abb << 1) + abb;     // 3ab^2, stays below m^3
      w2_q[2] <= (aab << 1) + aab;
      w2_q[3] <= CUBE_W'(aa1_q * a1_q);
      den2_q  <= CUBE_W'(mm1_q * m1_q);
      last2_q <= last1_q;
      err2_q  <= err1_q;
    end
  end

  // stage 3: weight times control point, one multiplier per term
  logic                     v3_q, last3_q, err3_q;
  logic signed [PROD_W-1:0] px3_q [CTRL_POINTS];
  logic signed [PROD_W-1:0] py3_q [CTRL_POINTS];
  logic [CUBE_W-1:0]        den3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en_i) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < CTRL_POINTS; k++) begin
        px3_q[k] <= $signed({1'b0, w2_q[k]}) * $signed(ctrl_x_i[k]);
        py3_q[k] <= $signed({1'b0, w2_q[k]}) * $signed(ctrl_y_i[k]);
      end
      den3_q  <= den2_q;
      last3_q <= last2_q;
      err3_q  <= err2_q;
    end
  end

  // stage 4: numerator sums
  logic                    v4_q, last4_q, err4_q;
  logic signed [SUM_W-1:0] nx4_q, ny4_q;
  logic [CUBE_W-1:0]       den4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en_i) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nx4_q <= SUM_W'(px3_q[0]) + SUM_W'(px3_q[1]) + SUM_W'(px3_q[2]) + SUM_W'(px3_q[3]);
      ny4_q <= SUM_W'(py3_q[0]) + SUM_W'(py3_q[1]) + SUM_W'(py3_q[2]) + SUM_W'(py3_q[3]);
      den4_q  <= den3_q;
      last4_q <= last3_q;
      err4_q  <= err3_q;
    end
  end

  // stage 5: magnitude plus half divisor, rounds ties away from zero
  logic [SUM_W-1:0]  magx, magy;
  logic [REM_W-1:0]  half;
  div_slot_t         slot_q;

  assign magx = nx4_q[SUM_W-1] ? SUM_W'(-nx4_q) : SUM_W'(nx4_q);
  assign magy = ny4_q[SUM_W-1] ? SUM_W'(-ny4_q) : SUM_W'(ny4_q);
  assign half = REM_W'(den4_q >> 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
    end else if (en_i) begin
      slot_q.valid <= v4_q;
      slot_q.rem_x <= REM_W'(magx) + half;
      slot_q.rem_y <= REM_W'(magy) + half;
      slot_q.den   <= den4_q;
      slot_q.quo_x <= '0;
      slot_q.quo_y <= '0;
      slot_q.neg_x <= nx4_q[SUM_W-1];
      slot_q.neg_y <= ny4_q[SUM_W-1];
      slot_q.last  <= last4_q;
      slot_q.err   <= err4_q;
    end
  end

  assign slot_o = slot_q;

endmodule

`default_nettype wire

@@ src/bcps_div_cell.sv @@
// ----------------------------------------------------------------------------
// bcps_div_cell
// One restoring division cell: resolves one quotient bit for x and y.
// ----------------------------------------------------------------------------
`default_nettype none

module bcps_div_cell (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              en_i,
  input  wire  [bcps_pkg::SH_W-1:0]        bit_i,
  input  bcps_pkg::div_slot_t              slot_i,
  output bcps_pkg::div_slot_t              slot_o
);
  import bcps_pkg::*;

  logic [REM_W-1:0] dsh;
  logic             gex, gey;
  div_slot_t        slot_d, slot_q;

  assign dsh = REM_W'(slot_i.den) << bit_i;
  assign gex = slot_i.rem_x >= dsh;
  assign gey = slot_i.rem_y >= dsh;

  always_comb begin
    slot_d = slot_i;
    if (gex) begin
      slot_d.rem_x = slot_i.rem_x - dsh;
      slot_d.quo_x = slot_i.quo_x | (QUO_W'(1) << bit_i);
    end
    if (gey) begin
      slot_d.rem_y = slot_i.rem_y - dsh;
      slot_d.quo_y = slot_i.quo_y | (QUO_W'(1) << bit_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
    end else if (en_i) begin
      slot_q <= slot_d;
    end
  end

  assign slot_o = slot_q;

endmodule

`default_nettype wire

@@ src/cubic_bezier_point_sampler.sv @@
// ----------------------------------------------------------------------------
// cubic_bezier_point_sampler
// Samples a cubic Bezier curve at t = index / (count - 1), exactly rounded.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake            Payload
// in        input      in_valid_i/in_ready_o   bcps_pkg::in_item_t
// out       output     out_valid_o/out_ready_i bcps_pkg::out_item_t
// cfg       input      cfg_we_i                cfg_idx_i, cfg_wdata_i
//
// One item per clock sustained while the output is not stalled. The path from the accepting edge
// to out_valid_o runs through 6 weight/sum registers (the first loads at the accepting
// edge), a row of 32 divider cells (one quotient bit per cell), and the
// output register.
// Reset clears all valid flags and the control points to zero.
// A stalled output freezes the whole pipeline; a one-entry skid buffer on
// the input keeps in_ready_o a registered signal.
// ----------------------------------------------------------------------------
`default_nettype none

module cubic_bezier_point_sampler (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  output logic                  in_ready_o,
  input  bcps_pkg::in_item_t    in_data_i,
  output logic                  out_valid_o,
  input  wire                   out_ready_i,
  output bcps_pkg::out_item_t   out_data_o,
  input  wire                   cfg_we_i,
  input  wire  [2:0]            cfg_idx_i,
  input  wire  [31:0]           cfg_wdata_i
);
  import bcps_pkg::*;

  // control point registers
  logic [CTRL_POINTS-1:0][COORD_W-1:0] ctrl_x_q, ctrl_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_x_q <= '0;
      ctrl_y_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_CTRL0_X: ctrl_x_q[0] <= cfg_wdata_i;
        REG_CTRL0_Y: ctrl_y_q[0] <= cfg_wdata_i;
        REG_CTRL1_X: ctrl_x_q[1] <= cfg_wdata_i;
        REG_CTRL1_Y: ctrl_y_q[1] <= cfg_wdata_i;
        REG_CTRL2_X: ctrl_x_q[2] <= cfg_wdata_i;
        REG_CTRL2_Y: ctrl_y_q[2] <= cfg_wdata_i;
        REG_CTRL3_X: ctrl_x_q[3] <= cfg_wdata_i;
        REG_CTRL3_Y: ctrl_y_q[3] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // pipeline advances whenever the output slot is free or being drained
  logic      en;
  logic      out_valid_q;
  out_item_t out_q;

  assign en = !out_valid_q || out_ready_i;

  // input skid: catches an item accepted during a stall
  logic     skid_valid_q;
  in_item_t skid_q;
  logic     pipe_valid;
  in_item_t pipe_item;

  assign in_ready_o = !skid_valid_q;
  assign pipe_valid = skid_valid_q || in_valid_i;
  assign pipe_item  = skid_valid_q ? skid_q : in_data_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_valid_q <= 1'b0;
    end else if (en) begin
      skid_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!en && in_valid_i && in_ready_o) begin
      skid_q <= in_data_i;
    end
  end

  // weights, sums and rounding offset
  div_slot_t chain [QUO_W+1];

  bcps_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (pipe_valid),
    .item_i   (pipe_item),
    .ctrl_x_i (ctrl_x_q),
    .ctrl_y_i (ctrl_y_q),
    .slot_o   (chain[0])
  );

  // divider row, most significant quotient bit first
  for (genvar g = 0; g < QUO_W; g++) begin : g_cell
    bcps_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .bit_i  (SH_W'(QUO_W - 1 - g)),
      .slot_i (chain[g]),
      .slot_o (chain[g+1])
    );
  end

  // sign restore and output register
  div_slot_t fin;
  assign fin = chain[QUO_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= fin.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.point_x     <= fin.neg_x ? COORD_W'(-fin.quo_x) : COORD_W'(fin.quo_x);
      out_q.point_y     <= fin.neg_y ? COORD_W'(-fin.quo_y) : COORD_W'(fin.quo_y);
      out_q.last_sample <= fin.last;
      out_q.index_error <= fin.err;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

@@ tb/sv/cubic_bezier_point_sampler_tb.sv @@
// ----------------------------------------------------------------------------
// cubic_bezier_point_sampler_tb
// Self-checking bench: directed corner items, then random sample requests
// under random stalls on both sides, with the control points rewritten
// between phases. A class predicts each curve point and checks results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

class bezier_point_board;
  logic signed [31:0] ctrl_x [4];
  logic signed [31:0] ctrl_y [4];
  bcps_pkg::out_item_t pending_points [$];
  int errors;

  function new();
    errors = 0;
    foreach (ctrl_x[k]) begin
      ctrl_x[k] = '0;
      ctrl_y[k] = '0;
    end
  endfunction

  function void set_ctrl(logic [2:0] idx, logic [31:0] val);
    if (idx[0]) ctrl_y[idx >> 1] = val;
    else ctrl_x[idx >> 1] = val;
  endfunction

  // nearest, ties away from zero
  function longint round_quot(longint num, longint den);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = (mag + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  function void note_request(bcps_pkg::in_item_t req);
    bcps_pkg::out_item_t p;
    longint cnt, idx, m, a, den, nx, ny, w;
    longint binom [4];
    binom = '{1, 3, 3, 1};
    cnt = req.point_count;
    idx = req.sample_index;
    if (cnt > bcps_pkg::MAX_SAMPLES) cnt = bcps_pkg::MAX_SAMPLES;
    p.index_error = (idx >= cnt);
    p.last_sample = (cnt >= 1) && (idx == cnt - 1);
    if (cnt < 2) begin
      p.point_x = ctrl_x[0];
      p.point_y = ctrl_y[0];
    end else begin
      m = cnt - 1;
      a = (idx > m) ? m : idx;
      den = m * m * m;
      nx = 0;
      ny = 0;
      for (int k = 0; k < 4; k++) begin
        w = binom[k];
        for (int j = 0; j < k; j++) w = w * a;
        for (int j = k; j < 3; j++) w = w * (m - a);
        nx += w * longint'(ctrl_x[k]);
        ny += w * longint'(ctrl_y[k]);
      end
      p.point_x = 32'(round_quot(nx, den));
      p.point_y = 32'(round_quot(ny, den));
    end
    pending_points.push_back(p);
  endfunction

  function void check_point(bcps_pkg::out_item_t got);
    bcps_pkg::out_item_t exp_p;
    if (pending_points.size() == 0) begin
      $display("%0t: unexpected point %h", $time, got);
      errors++;
      return;
    end
    exp_p = pending_points.pop_front();
    if (got.point_x !== exp_p.point_x) begin
      $display("%0t: point_x exp %h got %h", $time, exp_p.point_x, got.point_x);
      errors++;
    end
    if (got.point_y !== exp_p.point_y) begin
      $display("%0t: point_y exp %h got %h", $time, exp_p.point_y, got.point_y);
      errors++;
    end
    if (got.last_sample !== exp_p.last_sample) begin
      $display("%0t: last_sample exp %b got %b", $time, exp_p.last_sample,
               got.last_sample);
      errors++;
    end
    if (got.index_error !== exp_p.index_error) begin
      $display("%0t: index_error exp %b got %b", $time, exp_p.index_error,
               got.index_error);
      errors++;
    end
  endfunction
endclass

module cubic_bezier_point_sampler_tb;
  import bcps_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 60;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  in_item_t    in_data_i;
  logic        out_valid_o;
  logic        out_ready_i;
  out_item_t   out_data_o;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [31:0] cfg_wdata_i;

  bezier_point_board board;
  int  idle_cycles;
  bit  stim_done;
  bit  hold_off_req;   // sender asks the receiver for a long stall

  cubic_bezier_point_sampler u_dut (.*);

  always begin
    clk_i = 1'b1; #1;
    clk_i = 1'b0; #1;
  end

  // mostly short gaps, now and then a long one
  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Monitor: checks results and feeds the predictor on the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) board.note_request(in_data_i);
      if (out_valid_o && out_ready_i) board.check_point(out_data_o);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  // Watchdog on cycles without any accepted item.
  always @(posedge clk_i) begin
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver: random ready; one long hold-off on request to fill the pipe.
  initial begin
    int gap;
    out_ready_i = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        out_ready_i <= 1'b0;
        for (int c = 0; c < 150; c++) @(negedge clk_i);
        hold_off_req = 1'b0;
      end
      gap = (stim_done || $urandom_range(0, 3) == 0) ? 0 : rand_gap();
      if (gap == 0) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b0;
        for (int c = 1; c < gap; c++) @(negedge clk_i);
      end
    end
  end

  task automatic write_ctrl(logic [2:0] idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    board.set_ctrl(idx, val);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Offer one request and hold it until accepted; gap optional.
  task automatic send_sample(logic [8:0] idx, logic [9:0] cnt, bit gaps);
    int gap;
    gap = gaps ? rand_gap() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i.sample_index <= idx;
    in_data_i.point_count  <= cnt;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Let everything drain so the control points can change safely.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (board.pending_points.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  function automatic logic [31:0] rand_coord(int mode);
    case (mode)
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 1) ? 32'($urandom_range(0, 32'h0FFF_FFFF))
                                      : -32'($urandom_range(0, 32'h0FFF_FFFF));
      default: return $urandom();
    endcase
  endfunction

  // Mostly small counts; occasionally large or out-of-range ones.
  function automatic logic [9:0] rand_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 10'($urandom_range(0, 20));
    if (r < 90) return 10'($urandom_range(21, 512));
    return 10'($urandom_range(513, 1023));
  endfunction

  initial begin
    logic [9:0] cnt;
    logic [8:0] idx;
    board       = new();
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = REG_CTRL0_X;
    cfg_wdata_i = '0;
    idle_cycles = 0;
    stim_done   = 1'b0;
    hold_off_req = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset control points first (all zero), then extremes.
    send_sample(9'd0, 10'd4, 1'b0);
    drain();
    write_ctrl(REG_CTRL0_X, 32'h7FFF_FFFF);
    write_ctrl(REG_CTRL0_Y, 32'h8000_0000);
    write_ctrl(REG_CTRL1_X, 32'h8000_0000);
    write_ctrl(REG_CTRL1_Y, 32'h7FFF_FFFF);
    write_ctrl(REG_CTRL2_X, 32'h7FFF_FFFF);
    write_ctrl(REG_CTRL2_Y, 32'h8000_0000);
    write_ctrl(REG_CTRL3_X, 32'h8000_0000);
    write_ctrl(REG_CTRL3_Y, 32'h7FFF_FFFF);

    // Directed: count zero/one, index past count, saturation, ends, midpoints.
    send_sample(9'd0,   10'd0,    1'b0);
    send_sample(9'd0,   10'd1,    1'b0);
    send_sample(9'd1,   10'd1,    1'b0);
    send_sample(9'd5,   10'd0,    1'b0);
    send_sample(9'd0,   10'd2,    1'b0);
    send_sample(9'd1,   10'd2,    1'b0);
    send_sample(9'd2,   10'd2,    1'b0);
    send_sample(9'd1,   10'd3,    1'b0);
    send_sample(9'd511, 10'd512,  1'b0);
    send_sample(9'd510, 10'd512,  1'b0);
    send_sample(9'd255, 10'd512,  1'b0);
    send_sample(9'd1,   10'd512,  1'b0);
    send_sample(9'd511, 10'd1023, 1'b0);
    send_sample(9'd0,   10'd1023, 1'b0);
    send_sample(9'd511, 10'd513,  1'b0);
    send_sample(9'd511, 10'd100,  1'b0);
    send_sample(9'd170, 10'd511,  1'b0);
    send_sample(9'd3,   10'd7,    1'b0);
    drain();

    // Random phases with fresh control points; one back-pressure burst.
    for (int ph = 0; ph < 7; ph++) begin
      for (int r = 0; r < 8; r++)
        write_ctrl(3'(r), rand_coord((ph < 2) ? ph : $urandom_range(2, 3)));
      if (ph == 3) hold_off_req = 1'b1;
      for (int n = 0; n < 200; n++) begin
        cnt = rand_count();
        if ($urandom_range(0, 9) == 0 || cnt == 0)
          idx = 9'($urandom());
        else if ($urandom_range(0, 4) == 0)
          idx = (cnt > 512) ? 9'd511 : 9'(cnt - 1);
        else
          idx = 9'($urandom_range(0, (cnt > 512 ? 512 : cnt) - 1));
        send_sample(idx, cnt, (ph != 2) && !hold_off_req);
      end
      drain();
    end

    stim_done = 1'b1;
    in_valid_i <= 1'b0;
    if (board.errors == 0 && board.pending_points.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      if (board.pending_points.size() != 0)
        $display("%0t: %0d points never arrived", $time,
                 board.pending_points.size());
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
